// ----- design/snf_pkg.sv -----
`default_nettype none

package snf_pkg;

  // Sizes of the cluster buffer and of a range sample.
  localparam int unsigned ClusterDepth = 32;
  localparam int unsigned RangeBits    = 16;
  localparam int unsigned SizeBits     = 6;
  localparam int unsigned CntBits      = $clog2(ClusterDepth + 1);
  localparam int unsigned AddrBits     = $clog2(ClusterDepth);
  localparam int unsigned CfgIdxBits   = 3;

  typedef logic [RangeBits-1:0] range_t;
  typedef logic [CntBits-1:0]   cnt_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_BREAK_DIST = 3'd1,
    CFG_MAX_SIZE   = 3'd2,
    CFG_NOISE_DIST = 3'd3,
    CFG_FILL_RANGE = 3'd4
  } cfg_idx_e;

  // How buffered samples are rewritten while they are released.
  typedef enum logic [1:0] {
    DRAIN_PASS  = 2'd0,
    DRAIN_NOISE = 2'd1,
    DRAIN_ALL   = 2'd2
  } drain_mode_e;

  typedef struct packed {
    range_t range_in;
    logic   scan_end;
  } in_item_t;

  typedef struct packed {
    range_t range_out;
    logic   scan_end_out;
    logic   run_last;
  } out_item_t;

  typedef struct packed {
    logic                enable;
    range_t              break_distance;
    logic [SizeBits-1:0] max_cluster_size;
    range_t              max_noise_distance;
    range_t              fill_range;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;
    logic        push;
    logic        set_long;
    logic        brk_clr;
    logic        scan_clr;
    logic        keep_prev;
    logic        rep_latch;
    logic        drain_start;
    drain_mode_e drain_mode;
    logic        drain_last;
    logic        drain_load;
    logic        emit_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enable;
    logic scan_end;
    logic brk;
    logic noise;
    logic rep;
    logic push_full;
    logic cnt_zero;
    logic lim_gt1;
    logic drain_final;
    logic cluster_long;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/snf_cfg_regs.sv -----
`default_nettype none

module snf_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [snf_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [snf_pkg::RangeBits-1:0]         cfg_data_i,
  output snf_pkg::cfg_t                         cfg_o
);
  import snf_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:     cfg_d.enable             = cfg_data_i[0];
        CFG_BREAK_DIST: cfg_d.break_distance     = cfg_data_i;
        CFG_MAX_SIZE:   cfg_d.max_cluster_size   = cfg_data_i[SizeBits-1:0];
        CFG_NOISE_DIST: cfg_d.max_noise_distance = cfg_data_i;
        CFG_FILL_RANGE: cfg_d.fill_range         = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable             <= 1'b0;
      cfg_q.break_distance     <= range_t'(100);
      cfg_q.max_cluster_size   <= SizeBits'(5);
      cfg_q.max_noise_distance <= range_t'(1000);
      cfg_q.fill_range         <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/snf_datapath.sv -----
`default_nettype none

module snf_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  snf_pkg::cfg_t      cfg_i,
  input  snf_pkg::in_item_t  in_data_i,
  input  snf_pkg::cmd_t      cmd_i,
  input  logic               out_stall_i,
  output snf_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  output snf_pkg::out_item_t out_data_o
);
  import snf_pkg::*;

  // Captured request.
  range_t x_q;
  logic   end_q;

  // Scan and cluster state.
  range_t prev_q;
  logic   have_prev_q;
  logic   ef_q;
  cnt_t   count_q;
  logic   awn_q;
  logic   long_q;
  logic   rep_q;

  // Drain sequencing.
  cnt_t        k_q, k_d;
  drain_mode_e mode_q;
  logic        last_en_q;
  range_t      rd_q;

  // Cluster buffer.
  range_t mem [ClusterDepth];

  // Output register.
  logic      out_v_q;
  out_item_t out_q;

  logic             over_depth;
  cnt_t             lim;
  logic             further;
  range_t           diff;
  logic [CntBits:0] count_inc;
  logic [CntBits:0] k_inc;
  logic             drain_final;
  range_t           drain_val;
  range_t           emit_val;

  // Effective size limit, clipped to the buffer depth.
  assign over_depth = (32'(cfg_i.max_cluster_size) > 32'(ClusterDepth));
  assign lim = over_depth ? cnt_t'(ClusterDepth) : cnt_t'(cfg_i.max_cluster_size);

  // Jump between neighbours.
  assign further = (x_q > prev_q);
  assign diff    = further ? (x_q - prev_q) : (prev_q - x_q);

  assign count_inc   = {1'b0, count_q} + {{CntBits{1'b0}}, 1'b1};
  assign k_inc       = {1'b0, k_q} + {{CntBits{1'b0}}, 1'b1};
  assign drain_final = (k_inc == {1'b0, count_q});

  // Status for the controller.
  always_comb begin
    stat_o.enable       = cfg_i.enable;
    stat_o.scan_end     = end_q;
    stat_o.brk          = have_prev_q && (diff > cfg_i.break_distance);
    stat_o.noise        = !long_q && (count_q < lim) && (further != ef_q) && awn_q;
    stat_o.rep          = !long_q && (count_q < lim) && !ef_q;
    stat_o.push_full    = (count_inc >= {1'b0, lim});
    stat_o.cnt_zero     = (count_q == '0);
    stat_o.lim_gt1      = (lim > cnt_t'(1));
    stat_o.drain_final  = drain_final;
    stat_o.cluster_long = long_q;
    stat_o.out_free     = !out_v_q || !out_stall_i;
  end

  // Rewrite of a released sample.
  always_comb begin
    case (mode_q)
      DRAIN_ALL:   drain_val = cfg_i.fill_range;
      DRAIN_NOISE: drain_val = (rd_q < cfg_i.max_noise_distance) ? cfg_i.fill_range : rd_q;
      default:     drain_val = rd_q;
    endcase
  end

  assign emit_val = (cfg_i.enable && end_q && rep_q) ? cfg_i.fill_range : x_q;

  // Drain read index.
  always_comb begin
    if (cmd_i.drain_start) begin
      k_d = '0;
    end else if (cmd_i.drain_load) begin
      k_d = k_inc[CntBits-1:0];
    end else begin
      k_d = k_q;
    end
  end

  // Cluster buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[AddrBits-1:0]] <= x_q;
    end
    rd_q <= mem[k_d[AddrBits-1:0]];
  end

  // Captured request and drain settings.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= in_data_i.range_in;
      end_q <= in_data_i.scan_end;
    end
    if (cmd_i.drain_start) begin
      mode_q    <= cmd_i.drain_mode;
      last_en_q <= cmd_i.drain_last;
    end
    if (cmd_i.emit_load) begin
      out_q <= '{range_out: emit_val, scan_end_out: end_q, run_last: 1'b1};
    end else if (cmd_i.drain_load) begin
      out_q <= '{range_out: drain_val, scan_end_out: 1'b0,
                 run_last: last_en_q && drain_final};
    end
  end

  // Scan and cluster state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      ef_q        <= 1'b0;
      count_q     <= '0;
      awn_q       <= 1'b1;
      long_q      <= 1'b0;
      rep_q       <= 1'b0;
      k_q         <= '0;
      out_v_q     <= 1'b0;
    end else begin
      k_q     <= k_d;
      out_v_q <= cmd_i.emit_load || cmd_i.drain_load || (out_v_q && out_stall_i);
      if (cmd_i.rep_latch) begin
        rep_q <= stat_o.rep;
      end
      if (cmd_i.scan_clr) begin
        prev_q      <= '0;
        have_prev_q <= 1'b0;
        ef_q        <= 1'b0;
        count_q     <= '0;
        awn_q       <= 1'b1;
        long_q      <= 1'b0;
      end else if (cmd_i.brk_clr) begin
        ef_q    <= further;
        count_q <= '0;
        awn_q   <= 1'b1;
        long_q  <= 1'b0;
      end else begin
        if (cmd_i.push) begin
          count_q <= count_inc[CntBits-1:0];
          awn_q   <= awn_q && (x_q <= cfg_i.max_noise_distance);
        end else if (cmd_i.drain_load && drain_final) begin
          count_q <= '0;
        end
        if (cmd_i.set_long) begin
          long_q <= 1'b1;
        end
        if (cmd_i.push || cmd_i.keep_prev) begin
          prev_q      <= x_q;
          have_prev_q <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- design/snf_ctrl.sv -----
`default_nettype none

module snf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  snf_pkg::stat_t stat_i,
  output snf_pkg::cmd_t  cmd_o
);
  import snf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_STEP = 7'b0000100,
    S_BRK  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  logic        do_step;
  logic        drn_req;
  logic        drn_force;
  drain_mode_e drn_mode;
  logic        drn_last;
  state_e      drn_ret;

  // One request at a time.
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    ret_d     = ret_q;
    do_step   = 1'b0;
    drn_req   = 1'b0;
    drn_force = 1'b0;
    drn_mode  = DRAIN_PASS;
    drn_last  = 1'b0;
    drn_ret   = S_IDLE;

    // Main sequence.
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.enable) begin
          drn_req = 1'b1;
          drn_ret = S_EMIT;
        end else if (stat_i.brk) begin
          drn_req  = 1'b1;
          drn_mode = stat_i.noise ? DRAIN_NOISE : DRAIN_PASS;
          drn_last = !stat_i.scan_end && stat_i.lim_gt1;
          drn_ret  = S_BRK;
        end else begin
          do_step = 1'b1;
        end
      end
      S_BRK: begin
        cmd_o.brk_clr = 1'b1;
        state_d       = S_STEP;
      end
      S_STEP: begin
        do_step = 1'b1;
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.drain_load = 1'b1;
          if (stat_i.drain_final) begin
            state_d = ret_q;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (!stat_i.enable || stat_i.scan_end) begin
            cmd_o.scan_clr = 1'b1;
          end else begin
            cmd_o.keep_prev = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Handling of the sample itself, after any break has been resolved.
    if (do_step) begin
      if (stat_i.scan_end) begin
        cmd_o.rep_latch = 1'b1;
        drn_req         = 1'b1;
        drn_mode        = stat_i.rep ? DRAIN_ALL : DRAIN_PASS;
        drn_ret         = S_EMIT;
      end else if (stat_i.cluster_long) begin
        state_d = S_EMIT;
      end else begin
        cmd_o.push = 1'b1;
        if (stat_i.push_full) begin
          cmd_o.set_long = 1'b1;
          drn_req        = 1'b1;
          drn_force      = 1'b1;
          drn_last       = 1'b1;
          drn_ret        = S_IDLE;
        end else begin
          state_d = S_IDLE;
        end
      end
    end

    // Start of a release of the buffered cluster.
    if (drn_req) begin
      cmd_o.drain_start = 1'b1;
      cmd_o.drain_mode  = drn_mode;
      cmd_o.drain_last  = drn_last;
      ret_d             = drn_ret;
      state_d           = (drn_force || !stat_i.cnt_zero) ? S_RD : drn_ret;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/scan_noise_cluster_filter.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_data_i  (range_in, scan_end)
// out       output     out_valid_o/out_stall_i out_data_o (range_out, scan_end_out, run_last)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample that is only buffered passes the accept and evaluation states;
// a sample released directly also passes the emit state. Releasing a buffered
// cluster passes a read state, set by the registered read port of the cluster
// buffer, then the output state for each sample; a break adds the break and step states.
// Reset is asynchronous, active low; the buffer needs no clearing pass.
// A stalled output holds its result while the next request is evaluated.
module scan_noise_cluster_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  snf_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output snf_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [snf_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [snf_pkg::RangeBits-1:0]  cfg_data_i
);
  import snf_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers.
  snf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  snf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Cluster buffer, decisions and output register.
  snf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- design/snf_checker.sv -----
`default_nettype none

module snf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input snf_pkg::out_item_t out_data_o
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output result dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Only one request is in work at a time.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in work");

  // The scan end result always closes the results of its request.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scan_end_out |-> out_data_o.run_last)
    else $error("scan end result not marked as last");

  // A taken request raises no result before it has been evaluated.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared before the request was evaluated");

endmodule

bind scan_noise_cluster_filter snf_checker u_snf_checker (.*);

`default_nettype wire

// ----- bench/tb_scan_noise_cluster_filter.sv -----
`timescale 1ns / 100ps

module tb_scan_noise_cluster_filter;
  import snf_pkg::*;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Block ports.
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [RangeBits-1:0]  cfg_data_i = '0;

  scan_noise_cluster_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Samples waiting to be offered, and filtered samples still to arrive.
  in_item_t  sample_q[$];
  out_item_t filtered_q[$];

  // Run control shared by the processes.
  logic        in_taken = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned in_idle = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned n_err = 0;
  int unsigned n_req = 0;
  int unsigned n_res = 0;
  int unsigned n_scan_end = 0;
  int unsigned n_writes = 0;

  // Shadow of the filter registers and of its scan state.
  cfg_t filt_cfg = '{enable: 1'b0, break_distance: 16'd100, max_cluster_size: 6'd5,
                     max_noise_distance: 16'd1000, fill_range: 16'hffff};
  range_t      prev_rng = '0;
  logic        have_prev = 1'b0;
  logic        went_further = 1'b0;
  range_t      clu_buf[ClusterDepth];
  int unsigned clu_cnt = 0;
  logic        clu_long = 1'b0;
  logic        all_near = 1'b1;

  // Effective cluster size limit; anything above the buffer depth acts as the depth.
  function automatic int unsigned size_limit();
    return (filt_cfg.max_cluster_size > ClusterDepth) ? ClusterDepth
                                                       : filt_cfg.max_cluster_size;
  endfunction

  function automatic void emit_range(range_t r, logic last_of_scan);
    out_item_t o;
    o.range_out    = r;
    o.scan_end_out = last_of_scan;
    o.run_last     = 1'b0;
    filtered_q.insert(filtered_q.size(), o);
  endfunction

  function automatic void forget_cluster();
    clu_cnt  = 0;
    clu_long = 1'b0;
    all_near = 1'b1;
  endfunction

  // Release the buffered cluster, rewriting samples as the mode asks.
  function automatic void release_cluster(drain_mode_e mode);
    range_t      r;
    int unsigned k;
    for (k = 0; k < clu_cnt; k++) begin
      r = clu_buf[k];
      if (mode == DRAIN_ALL || (mode == DRAIN_NOISE && r < filt_cfg.max_noise_distance)) begin
        r = filt_cfg.fill_range;
      end
      emit_range(r, 1'b0);
    end
    clu_cnt = 0;
  endfunction

  // Work out the filtered samples that one accepted request releases.
  function automatic void filter_sample(in_item_t req);
    range_t      x;
    range_t      jump;
    logic        further;
    logic        noise;
    logic        replace;
    int unsigned base;
    base = filtered_q.size();
    x    = req.range_in;
    if (!filt_cfg.enable) begin
      // Pass-through: flush what is held and forget the scan.
      release_cluster(DRAIN_PASS);
      emit_range(x, req.scan_end);
      have_prev    = 1'b0;
      went_further = 1'b0;
      forget_cluster();
    end else begin
      // A large jump closes the cluster holding the previous sample.
      if (have_prev) begin
        jump = (x > prev_rng) ? x - prev_rng : prev_rng - x;
        if (jump > filt_cfg.break_distance) begin
          further = (x > prev_rng);
          noise   = !clu_long && clu_cnt < size_limit() && further != went_further && all_near;
          release_cluster(noise ? DRAIN_NOISE : DRAIN_PASS);
          went_further = further;
          forget_cluster();
        end
      end
      if (req.scan_end) begin
        // A short open cluster not entered by a further jump is removed with the last sample.
        replace = !clu_long && clu_cnt < size_limit() && !went_further;
        release_cluster(replace ? DRAIN_ALL : DRAIN_PASS);
        emit_range(replace ? filt_cfg.fill_range : x, 1'b1);
        have_prev    = 1'b0;
        went_further = 1'b0;
        prev_rng     = '0;
        forget_cluster();
      end else begin
        if (clu_long) begin
          emit_range(x, 1'b0);
        end else begin
          if (clu_cnt < ClusterDepth) begin
            clu_buf[clu_cnt] = x;
            clu_cnt++;
          end
          if (x > filt_cfg.max_noise_distance) all_near = 1'b0;
          // Once the cluster reaches the limit it can no longer be noise.
          if (clu_cnt >= size_limit()) begin
            release_cluster(DRAIN_PASS);
            clu_long = 1'b1;
          end
        end
        prev_rng  = x;
        have_prev = 1'b1;
      end
    end
    if (filtered_q.size() > base) filtered_q[filtered_q.size()-1].run_last = 1'b1;
  endfunction

  // Monitor: register writes, accepted requests and released samples.
  always @(posedge clk_i) begin : watch
    out_item_t got;
    out_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        n_writes++;
        case (cfg_idx_e'(cfg_index_i))
          CFG_ENABLE:     filt_cfg.enable = cfg_data_i[0];
          CFG_BREAK_DIST: filt_cfg.break_distance = cfg_data_i;
          CFG_MAX_SIZE:   filt_cfg.max_cluster_size = cfg_data_i[SizeBits-1:0];
          CFG_NOISE_DIST: filt_cfg.max_noise_distance = cfg_data_i;
          CFG_FILL_RANGE: filt_cfg.fill_range = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        n_req++;
        if (in_data_i.scan_end) n_scan_end++;
        filter_sample(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        n_res++;
        if (filtered_q.size() == 0) begin
          $error("unexpected sample: range_out %0d, scan_end_out %0b, run_last %0b",
                 got.range_out, got.scan_end_out, got.run_last);
          n_err++;
        end else begin
          want = filtered_q.pop_front();
          if (got.range_out !== want.range_out) begin
            $error("range_out: expected %0d, got %0d", want.range_out, got.range_out);
            n_err++;
          end
          if (got.scan_end_out !== want.scan_end_out) begin
            $error("scan_end_out: expected %0b, got %0b", want.scan_end_out, got.scan_end_out);
            n_err++;
          end
          if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            n_err++;
          end
        end
      end
    end
  end

  // Driver: offers queued samples, with random gaps between requests.
  always @(negedge clk_i) begin : drive_req
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (in_taken || !in_valid_i) begin
      if (in_taken) begin
        in_taken = 1'b0;
        void'(sample_q.pop_front());
      end
      nxt_valid = 1'b0;
      if (in_idle > 0) begin
        in_idle--;
      end else if (sample_q.size() != 0) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          in_idle = $urandom_range(0, 2);
        end else begin
          nxt_valid = 1'b1;
          nxt_data  = sample_q[0];
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // Receiver: random stall bursts, and a long hold-off when asked for.
  always @(negedge clk_i) begin : drive_stall
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 99;
      nxt_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_stall = 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 2);
      nxt_stall  = 1'b1;
    end
    out_stall_i <= nxt_stall;
  end

  task automatic add_req(range_t r, logic last_of_scan);
    in_item_t it;
    it.range_in = r;
    it.scan_end = last_of_scan;
    sample_q.insert(sample_q.size(), it);
  endtask

  // Register write; only issued while the filter is idle.
  task automatic write_reg(cfg_idx_e idx, range_t value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Wait until every request is taken and every filtered sample has arrived,
  // then give a buffered last sample time to settle.
  task automatic wait_drained();
    while (sample_q.size() != 0 || filtered_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic range_t pick_range(logic near_side);
    if (near_side) return range_t'($urandom_range(0, filt_cfg.max_noise_distance));
    return range_t'($urandom_range(filt_cfg.max_noise_distance, 65535));
  endfunction

  // Mostly well-formed scans: clusters of close samples split by jumps
  // between near and far ranges, with some arbitrary samples mixed in.
  task automatic queue_traffic(int unsigned n_items, int unsigned long_pct);
    int unsigned added;
    int unsigned len;
    int unsigned k;
    int          v;
    range_t      r;
    logic        near_side;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        for (k = 0; k < 3; k++) begin
          add_req(range_t'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
        end
        added += 3;
      end else begin
        near_side = $urandom_range(0, 1);
        r   = pick_range(near_side);
        len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(6, 36) : $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          add_req(r, 1'b0);
          v = int'($urandom_range(0, filt_cfg.break_distance / 2));
          if ($urandom_range(0, 1)) v = -v;
          v = v + int'(r);
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          r = range_t'(v);
        end
        added += len;
        if ($urandom_range(0, 3) == 0) begin
          add_req(pick_range($urandom_range(0, 1)), 1'b1);
          added++;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Disabled after reset: samples pass unchanged.
    add_req(16'd0, 1'b0);
    add_req(16'hffff, 1'b1);
    wait_drained();
    write_reg(CFG_ENABLE, 16'd1);

    // Single-sample scan.
    add_req(16'd500, 1'b1);
    // Near cluster between far samples; the sample at the noise bound is kept.
    add_req(16'd5000, 1'b0);
    add_req(16'd200, 1'b0);
    add_req(16'd1000, 1'b0);
    add_req(16'd5000, 1'b0);
    // Cluster that reaches the size limit and passes through.
    add_req(16'd4000, 1'b0);
    add_req(16'd4010, 1'b0);
    add_req(16'd4020, 1'b0);
    add_req(16'd4030, 1'b0);
    add_req(16'd4040, 1'b0);
    add_req(16'd4050, 1'b0);
    // Extreme ranges forming a one-sample noise cluster.
    add_req(16'd0, 1'b0);
    add_req(16'hffff, 1'b0);
    // Scan end on a short cluster entered by a nearer jump.
    add_req(16'd300, 1'b0);
    add_req(16'd310, 1'b1);
    // First cluster of a scan, then scan end after a further jump.
    add_req(16'd300, 1'b0);
    add_req(16'd8000, 1'b0);
    add_req(16'd8010, 1'b1);
    wait_drained();

    // Reset settings, with a long receiver hold-off at the start.
    idle_pct = 30;
    hold_req = 1'b1;
    queue_traffic(50, 8);
    wait_drained();

    // Every change breaks, widest limit, everything counts as near.
    write_reg(CFG_BREAK_DIST, 16'd0);
    write_reg(CFG_MAX_SIZE, 16'd32);
    write_reg(CFG_NOISE_DIST, 16'hffff);
    write_reg(CFG_FILL_RANGE, 16'd0);
    idle_pct = 0;
    queue_traffic(45, 10);
    wait_drained();

    // Nothing ever breaks, a limit of one, only a range of zero counts as near.
    write_reg(CFG_BREAK_DIST, 16'hffff);
    write_reg(CFG_MAX_SIZE, 16'd1);
    write_reg(CFG_NOISE_DIST, 16'd0);
    write_reg(CFG_FILL_RANGE, 16'hffff);
    idle_pct = 40;
    queue_traffic(40, 8);
    wait_drained();

    // A limit of zero: no cluster is ever noise.
    write_reg(CFG_BREAK_DIST, 16'd100);
    write_reg(CFG_MAX_SIZE, 16'd0);
    write_reg(CFG_NOISE_DIST, 16'd1000);
    idle_pct = 20;
    queue_traffic(40, 8);
    wait_drained();

    // A limit above the buffer depth, with long clusters.
    write_reg(CFG_BREAK_DIST, 16'd50);
    write_reg(CFG_MAX_SIZE, 16'd63);
    write_reg(CFG_NOISE_DIST, 16'd2000);
    write_reg(CFG_FILL_RANGE, 16'd12345);
    idle_pct = 25;
    queue_traffic(50, 50);
    wait_drained();

    // Disabled in the middle of an open cluster.
    write_reg(CFG_ENABLE, 16'd0);
    idle_pct = 30;
    queue_traffic(30, 8);
    wait_drained();

    // Enabled again with random settings and no idling to the end.
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_BREAK_DIST, range_t'($urandom_range(0, 300)));
    write_reg(CFG_MAX_SIZE, range_t'($urandom_range(1, 8)));
    write_reg(CFG_NOISE_DIST, range_t'($urandom_range(200, 3000)));
    write_reg(CFG_FILL_RANGE, range_t'($urandom_range(0, 65535)));
    idle_pct = 0;
    queue_traffic(45, 8);
    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("Run covered %0d samples over %0d scan ends, %0d register writes.",
             n_req, n_scan_end, n_writes);
    $display("Checked %0d filtered samples, %0d mismatches.", n_res, n_err);
    if (n_err == 0 && filtered_q.size() == 0) begin
      $display("** scan_noise_cluster_filter: PASSED **");
    end else begin
      $display("** scan_noise_cluster_filter: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("** scan_noise_cluster_filter: FAILED **");
    $finish;
  end

endmodule
